/* src/q2rm_pkg.sv */
// Package for the quaternion to rotation matrix block.
// Holds the fixed payload widths and the input and result beat structs.
package q2rm_pkg;

  localparam int unsigned QW = 16;
  localparam int unsigned FB = 14;

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
  } q2rm_in_t;

  typedef struct packed {
    logic signed [QW-1:0] c0r0;
    logic signed [QW-1:0] c0r1;
    logic signed [QW-1:0] c0r2;
    logic signed [QW-1:0] c1r0;
    logic signed [QW-1:0] c1r1;
    logic signed [QW-1:0] c1r2;
    logic signed [QW-1:0] c2r0;
    logic signed [QW-1:0] c2r1;
    logic signed [QW-1:0] c2r2;
    logic                 zero_norm;
  } q2rm_out_t;

  // Numerators and norm handed from the front part to the back part.
  localparam int unsigned NW = 2*QW + 3;
  typedef struct packed {
    logic signed [NW-1:0] num0;
    logic signed [NW-1:0] num1;
    logic signed [NW-1:0] num2;
    logic signed [NW-1:0] num3;
    logic signed [NW-1:0] num4;
    logic signed [NW-1:0] num5;
    logic signed [NW-1:0] num6;
    logic signed [NW-1:0] num7;
    logic signed [NW-1:0] num8;
    logic [NW-1:0]        norm;
    logic                 zero_norm;
  } q2rm_work_t;

endpackage

/* src/quaternion_to_rotation_matrix_top.sv */
// Quaternion to rotation matrix: top level joining front, queue and back.
// Depends on q2rm_pkg, q2rm_front, q2rm_fifo and q2rm_back.
//
// Usage: in_valid/in_ready carry one quaternion (w,x,y,z, signed Q1.14) per
// beat; out_valid/out_ready carry the nine column-major matrix entries of
// the normalized quaternion (Q1.14, rounded to nearest, ties away from zero)
// and the zero_norm flag. An all-zero quaternion yields the identity with
// zero_norm set.
// Throughput: one beat per cycle while out_ready is high, set by the fully
// pipelined divider array. Stages: two front stages (products, sums), the
// queue, and 17 divider stages (load, leading bit, 14 fraction bits, round
// bit).
// Reset: rst_n synchronous active low empties every stage and the queue.
// Stall: when out_ready is low the results hold; the divider stages, the
// queue and the front stages fill, and in_ready drops once 21 beats are held.
module quaternion_to_rotation_matrix_top
  import q2rm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  q2rm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output q2rm_out_t out_data
);

  logic       fr_valid, fr_ready, bk_valid, bk_ready;
  q2rm_work_t fr_data, bk_data;

  q2rm_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .fr_valid, .fr_ready, .fr_data
  );

  q2rm_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(fr_valid), .wr_ready(fr_ready), .wr_data(fr_data),
    .rd_valid(bk_valid), .rd_ready(bk_ready), .rd_data(bk_data)
  );

  q2rm_back u_back (
    .clk, .rst_n, .bk_valid, .bk_ready, .bk_data,
    .out_valid, .out_ready, .out_data
  );

endmodule

/* src/q2rm_front.sv */
// Front part: products, numerators and the norm, over two register stages.
// Depends on q2rm_pkg.
module q2rm_front
  import q2rm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  q2rm_in_t   in_data,
  output logic       fr_valid,
  input  logic       fr_ready,
  output q2rm_work_t fr_data
);

  localparam int unsigned PW = 2*QW;

  logic              s1_valid_r;
  logic signed [PW-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic              s2_valid_r;
  q2rm_work_t        s2_r;
  logic              adv2, adv1;

  assign adv2     = !s2_valid_r || fr_ready;
  assign adv1     = !s1_valid_r || adv2;
  assign in_ready = adv1;

  // Stage one: ten products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv1) begin
      s1_valid_r <= in_valid;
    end
    if (adv1 && in_valid) begin
      ww_r <= PW'(in_data.quat_w * in_data.quat_w);
      xx_r <= PW'(in_data.quat_x * in_data.quat_x);
      yy_r <= PW'(in_data.quat_y * in_data.quat_y);
      zz_r <= PW'(in_data.quat_z * in_data.quat_z);
      xy_r <= PW'(in_data.quat_x * in_data.quat_y);
      xz_r <= PW'(in_data.quat_x * in_data.quat_z);
      yz_r <= PW'(in_data.quat_y * in_data.quat_z);
      wx_r <= PW'(in_data.quat_w * in_data.quat_x);
      wy_r <= PW'(in_data.quat_w * in_data.quat_y);
      wz_r <= PW'(in_data.quat_w * in_data.quat_z);
    end
  end

  // Stage two: sums of products and the zero check.
  q2rm_work_t s2_nxt;
  always_comb begin
    logic signed [NW-1:0] ew, ex, ey, ez;
    ew = NW'(ww_r); ex = NW'(xx_r); ey = NW'(yy_r); ez = NW'(zz_r);
    s2_nxt.num0 = ew + ex - ey - ez;
    s2_nxt.num1 = (NW'(xy_r) + NW'(wz_r)) <<< 1;
    s2_nxt.num2 = (NW'(xz_r) - NW'(wy_r)) <<< 1;
    s2_nxt.num3 = (NW'(xy_r) - NW'(wz_r)) <<< 1;
    s2_nxt.num4 = ew - ex + ey - ez;
    s2_nxt.num5 = (NW'(yz_r) + NW'(wx_r)) <<< 1;
    s2_nxt.num6 = (NW'(xz_r) + NW'(wy_r)) <<< 1;
    s2_nxt.num7 = (NW'(yz_r) - NW'(wx_r)) <<< 1;
    s2_nxt.num8 = ew - ex - ey + ez;
    s2_nxt.norm = NW'(ew + ex + ey + ez);
    s2_nxt.zero_norm = (s2_nxt.norm == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv2) begin
      s2_valid_r <= s1_valid_r;
    end
    if (adv2 && s1_valid_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign fr_valid = s2_valid_r;
  assign fr_data  = s2_r;

endmodule

/* src/q2rm_fifo.sv */
// Two-entry queue between the front and back parts.
// Depends on q2rm_pkg.
module q2rm_fifo
  import q2rm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  q2rm_work_t wr_data,
  output logic       rd_valid,
  input  logic       rd_ready,
  output q2rm_work_t rd_data
);

  q2rm_work_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= !wp_r;
      if (rd_en) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !rd_en) |=> cnt_r == 2'd2)
    else $error("full queue lost an entry");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && !wr_en) |=> cnt_r == 2'd0)
    else $error("empty queue gained an entry");

endmodule

/* src/q2rm_back.sv */
// Back part: nine restoring dividers, one quotient bit per stage, then rounding.
// Depends on q2rm_pkg.
module q2rm_back
  import q2rm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       bk_valid,
  output logic       bk_ready,
  input  q2rm_work_t bk_data,
  output logic       out_valid,
  input  logic       out_ready,
  output q2rm_out_t  out_data
);

  // Stages: one for the leading bit, FB fraction bits, one round bit.
  localparam int unsigned NS = FB + 2;
  localparam int unsigned QB = FB + 2;
  localparam int unsigned RW = NW + 1;

  typedef struct packed {
    logic [8:0]           neg;
    logic [8:0][RW-1:0]   rem;
    logic [8:0][QB-1:0]   quo;
    logic [NW-1:0]        norm;
    logic                 zero_norm;
  } lane_t;

  logic [NS:0] vld_r;
  lane_t       st_r [NS+1];
  lane_t       st_nxt [NS+1];
  logic [NS:0] adv;
  q2rm_out_t   res;

  // Stage zero loads magnitudes.
  always_comb begin
    logic signed [NW-1:0] nm [9];
    nm[0] = bk_data.num0; nm[1] = bk_data.num1; nm[2] = bk_data.num2;
    nm[3] = bk_data.num3; nm[4] = bk_data.num4; nm[5] = bk_data.num5;
    nm[6] = bk_data.num6; nm[7] = bk_data.num7; nm[8] = bk_data.num8;
    st_nxt[0].norm      = bk_data.norm;
    st_nxt[0].zero_norm = bk_data.zero_norm;
    for (int k = 0; k < 9; k++) begin
      st_nxt[0].neg[k] = nm[k][NW-1];
      st_nxt[0].rem[k] = nm[k][NW-1] ? RW'(-nm[k]) : RW'(nm[k]);
      st_nxt[0].quo[k] = '0;
    end
  end

  // Each later stage compares, subtracts and shifts one bit.
  for (genvar s = 1; s <= NS; s++) begin : g_stage
    always_comb begin
      logic [RW-1:0] r;
      st_nxt[s] = st_r[s-1];
      for (int k = 0; k < 9; k++) begin
        r = (s == 1) ? st_r[s-1].rem[k] : (st_r[s-1].rem[k] << 1);
        if (r >= RW'(st_r[s-1].norm)) begin
          st_nxt[s].rem[k] = r - RW'(st_r[s-1].norm);
          st_nxt[s].quo[k] = (st_r[s-1].quo[k] << 1) | QB'(1);
        end else begin
          st_nxt[s].rem[k] = r;
          st_nxt[s].quo[k] = st_r[s-1].quo[k] << 1;
        end
      end
    end
  end

  // Pipeline advance with per-stage bubbles squeezed out.
  always_comb begin
    adv[NS] = !vld_r[NS] || out_ready;
    for (int s = NS - 1; s >= 0; s--) adv[s] = !vld_r[s] || adv[s+1];
  end
  assign bk_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= bk_valid;
      for (int s = 1; s <= NS; s++) begin
        if (adv[s]) vld_r[s] <= vld_r[s-1];
      end
    end
    if (adv[0] && bk_valid) st_r[0] <= st_nxt[0];
    for (int s = 1; s <= NS; s++) begin
      if (adv[s] && vld_r[s-1]) st_r[s] <= st_nxt[s];
    end
  end

  // Rounding, sign and identity substitution.
  always_comb begin
    logic [QB-1:0]        q;
    logic signed [QW-1:0] v [9];
    for (int k = 0; k < 9; k++) begin
      q = (st_r[NS].quo[k] >> 1) + QB'(st_r[NS].quo[k][0]);
      if (st_r[NS].zero_norm)
        v[k] = (k == 0 || k == 4 || k == 8) ? QW'(1 << FB) : '0;
      else
        v[k] = st_r[NS].neg[k] ? -QW'(q) : QW'(q);
    end
    res.c0r0 = v[0]; res.c0r1 = v[1]; res.c0r2 = v[2];
    res.c1r0 = v[3]; res.c1r1 = v[4]; res.c1r2 = v[5];
    res.c2r0 = v[6]; res.c2r1 = v[7]; res.c2r2 = v[8];
    res.zero_norm = st_r[NS].zero_norm;
  end

  assign out_valid = vld_r[NS];
  assign out_data  = res;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_norm) |-> out_data.c0r1 == '0)
    else $error("zero quaternion not identity");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.c0r0 <= QW'(1 << FB) && out_data.c0r0 >= -QW'(1 << FB)))
    else $error("entry out of unit range");

endmodule

/* test/tb.sv */
// Testbench for the quaternion to rotation matrix block.
// Depends on q2rm_pkg and quaternion_to_rotation_matrix_top; a scoreboard class
// predicts each matrix from the accepted quaternion and checks result beats.
`timescale 1ns / 100ps

module tb;
  import q2rm_pkg::*;

  // Scoreboard: predicts matrices in order and compares result beats.
  class rot_scoreboard;
    q2rm_out_t pending_q[$];
    int errors;

    // Rounded |num|/n * 2^FB with ties away from zero, sign applied after.
    function automatic longint scaled_ratio(longint num, longint n);
      longint mag;
      longint q;
      longint r;
      mag = (num < 0) ? -num : num;
      q = (mag << (FB + 1)) / n;
      q = (q + 1) >>> 1;
      r = 0;
      r = (num < 0) ? -q : q;
      if (r > (1 << FB)) r = 1 << FB;
      if (r < -(1 << FB)) r = -(1 << FB);
      return r;
    endfunction

    function void note_quat(q2rm_in_t q);
      longint w, x, y, z, ww, xx, yy, zz, n;
      q2rm_out_t m;
      w = q.quat_w;
      x = q.quat_x;
      y = q.quat_y;
      z = q.quat_z;
      ww = w * w;
      xx = x * x;
      yy = y * y;
      zz = z * z;
      n = ww + xx + yy + zz;
      m = '0;
      if (n == 0) begin
        m.c0r0 = QW'(1 << FB);
        m.c1r1 = QW'(1 << FB);
        m.c2r2 = QW'(1 << FB);
        m.zero_norm = 1'b1;
      end else begin
        m.c0r0 = QW'(scaled_ratio(ww + xx - yy - zz, n));
        m.c0r1 = QW'(scaled_ratio(2 * (x * y + w * z), n));
        m.c0r2 = QW'(scaled_ratio(2 * (x * z - w * y), n));
        m.c1r0 = QW'(scaled_ratio(2 * (x * y - w * z), n));
        m.c1r1 = QW'(scaled_ratio(ww - xx + yy - zz, n));
        m.c1r2 = QW'(scaled_ratio(2 * (y * z + w * x), n));
        m.c2r0 = QW'(scaled_ratio(2 * (x * z + w * y), n));
        m.c2r1 = QW'(scaled_ratio(2 * (y * z - w * x), n));
        m.c2r2 = QW'(scaled_ratio(ww - xx - yy + zz, n));
      end
      pending_q.push_back(m);
    endfunction

    function void check_matrix(q2rm_out_t got);
      q2rm_out_t exp_m;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp_m = pending_q.pop_front();
      if (got !== exp_m) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %h got %h", exp_m, got);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  q2rm_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  q2rm_out_t out_data;

  rot_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off;

  quaternion_to_rotation_matrix_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // Monitor: note accepted quaternions and check result beats.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_quat(in_data);
      if (out_valid && out_ready) sb.check_matrix(out_data);
    end
  end

  // Receiver: random stalls plus an optional long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one quaternion and hold it until accepted; valid stays high
  // into the next beat unless the sender idles.
  task automatic send_quat(q2rm_in_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic q2rm_in_t rand_quat();
    q2rm_in_t q;
    int kind;
    kind = $urandom_range(9);
    q = {$urandom, $urandom};
    if (kind < 2) begin
      // Small magnitudes where rounding is coarse.
      q.quat_w = QW'(int'($urandom_range(6)) - 3);
      q.quat_x = QW'(int'($urandom_range(6)) - 3);
      q.quat_y = QW'(int'($urandom_range(6)) - 3);
      q.quat_z = QW'(int'($urandom_range(6)) - 3);
    end else if (kind == 2) begin
      q.quat_x = '0;
      q.quat_z = '0;
    end
    return q;
  endfunction

  task automatic run_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) send_quat(rand_quat());
  endtask

  initial begin
    q2rm_in_t q;
    logic signed [15:0] edges [6];
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    edges = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd1, -16'sd1, 16'sd16384};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: all-zero, extremes, single-axis and mixed signs.
    send_quat('0);
    for (int i = 0; i < 6; i++) begin
      q = '0;
      q.quat_w = edges[i];
      q.quat_x = edges[(i + 1) % 6];
      q.quat_y = edges[(i + 2) % 6];
      q.quat_z = edges[(i + 3) % 6];
      send_quat(q);
    end
    send_quat({4{16'sh8000}});
    send_quat({4{16'sh7fff}});
    send_quat({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
    for (int a = 0; a < 4; a++) begin
      q = '0;
      q[63 - 16 * a -: 16] = 16'sh8000;
      send_quat(q);
      q[63 - 16 * a -: 16] = 16'sd1;
      send_quat(q);
    end
    send_quat({16'sd1, 16'sd1, 16'sd1, 16'sd1});
    send_quat({16'sd16384, 16'sd0, 16'sd0, 16'sd16384});

    // Long hold-off so the block fills and drops in_ready.
    hold_off = 200;
    run_phase(0, 0, 150);
    run_phase(81, 0, 200);
    run_phase(0, 81, 200);
    run_phase(37, 37, 200);
    run_phase(0, 0, 130);
    in_valid <= 1'b0;

    begin : drain
      int waited;
      waited = 0;
      while (sb.pending_q.size() != 0 && waited < 20000) begin
        @(posedge clk);
        waited++;
      end
    end
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
